### rtl/dda_pkg.sv
// Shared types and constants for the three-axis line stepper.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

	localparam int unsigned FracBitsDef = 30;
	localparam int unsigned PosBitsDef  = 32;
	localparam int unsigned CoordW      = 32;
	localparam int unsigned NumAxes     = 3;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_SET   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAD,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [CoordW-1:0] target_x;
		logic signed [CoordW-1:0] target_y;
		logic signed [CoordW-1:0] target_z;
	} cmd_beat_t;

	typedef struct packed {
		logic step_x;
		logic step_y;
		logic step_z;
		logic dir_x;
		logic dir_y;
		logic dir_z;
		logic moving;
		logic done_res;
		logic z_disable;
	} step_beat_t;

	typedef struct packed {
		logic start;
		logic set;
		logic div_go;
		logic tick_add;
		logic tick_end;
	} lane_ctl_t;

	typedef struct packed {
		logic dir;
		logic at_dest;
		logic step_add;
		logic div_busy;
	} lane_sts_t;

endpackage

`default_nettype wire

### rtl/dda_if.sv
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none

interface dda_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/dda_div.sv
// Serial restoring divider giving the fractional rate of one axis, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dda_div #(
	parameter int unsigned FRAC_BITS = dda_pkg::FracBitsDef,
	parameter int unsigned POS_BITS  = dda_pkg::PosBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [POS_BITS-1:0] num,
	input  logic [POS_BITS-1:0] den,
	output logic                busy,
	output logic                fin,
	output logic [FRAC_BITS:0]  quo
);
	localparam int unsigned CntW = $clog2(FRAC_BITS + 1);

	logic [POS_BITS:0]    rem_q;
	logic [POS_BITS-1:0]  den_q;
	logic [FRAC_BITS:0]   quo_q;
	logic [CntW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 fin_q;
	logic                 ge;
	logic [POS_BITS:0]    sub;
	logic [POS_BITS:0]    rem_keep;

	// num <= den, so the remainder stays below den and fits after the shift
	assign ge       = rem_q >= {1'b0, den_q};
	assign sub      = rem_q - {1'b0, den_q};
	assign rem_keep = ge ? sub : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_keep[POS_BITS-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign busy = busy_q;
	assign fin  = fin_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### rtl/dda_axis.sv
// One axis lane: position, destination, DDA accumulator, rate and its divider.
`timescale 1ns / 1ps
`default_nettype none

module dda_axis #(
	parameter int unsigned FRAC_BITS = dda_pkg::FracBitsDef,
	parameter int unsigned POS_BITS  = dda_pkg::PosBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dda_pkg::lane_ctl_t  ctl,
	input  logic [POS_BITS-1:0] target,
	input  logic [POS_BITS-1:0] lead,
	output logic [POS_BITS-1:0] mag,
	output dda_pkg::lane_sts_t  sts
);
	import dda_pkg::*;

	// only the lowest integer bit is kept: one tick moves the integer part by at most one
	localparam int unsigned AccW  = FRAC_BITS + 1;
	localparam int unsigned RateW = FRAC_BITS + 2;

	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] dest_q;
	logic [POS_BITS-1:0] mag_q;
	logic                neg_q;
	logic                dir_q;
	logic [AccW-1:0]     acc_q;
	logic [RateW-1:0]    rate_q;

	logic [POS_BITS:0]   diff;
	logic [POS_BITS:0]   dabs;
	logic [AccW-1:0]     acc_sum;
	logic                step_add;
	logic                at_dest;
	logic [POS_BITS-1:0] pos_step;
	logic                div_busy;
	logic                div_fin;
	logic [FRAC_BITS:0]  quo;
	logic [RateW-1:0]    rate_nxt;

	assign diff     = {target[POS_BITS-1], target} - {pos_q[POS_BITS-1], pos_q};
	assign dabs     = diff[POS_BITS] ? (~diff) + {{POS_BITS{1'b0}}, 1'b1} : diff;
	assign acc_sum  = acc_q + rate_q[AccW-1:0];
	assign step_add = acc_sum[FRAC_BITS] != acc_q[FRAC_BITS];
	assign at_dest  = pos_q == dest_q;
	assign pos_step = pos_q + {{(POS_BITS-1){~dir_q}}, 1'b1};
	assign rate_nxt = neg_q ? (~{1'b0, quo}) + {{(RateW-1){1'b0}}, 1'b1} : {1'b0, quo};

	dda_div #(
		.FRAC_BITS(FRAC_BITS),
		.POS_BITS (POS_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (ctl.div_go),
		.num   (mag_q),
		.den   (lead),
		.busy  (div_busy),
		.fin   (div_fin),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dest_q <= '0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			dir_q  <= 1'b0;
			acc_q  <= '0;
			rate_q <= '0;
		end else begin
			if (ctl.set) begin
				pos_q <= target;
			end else if ((ctl.tick_add && step_add) || (ctl.tick_end && !at_dest)) begin
				pos_q <= pos_step;
			end
			if (ctl.start) begin
				dest_q <= target;
				mag_q  <= dabs[POS_BITS-1:0];
				neg_q  <= diff[POS_BITS];
				dir_q  <= !diff[POS_BITS] && (diff != '0);
				acc_q  <= {pos_q[0], {FRAC_BITS{1'b0}}};
			end else if (ctl.tick_add) begin
				acc_q <= acc_sum;
			end
			if (div_fin) begin
				rate_q <= rate_nxt;
			end
		end
	end

	assign mag          = mag_q;
	assign sts.dir      = dir_q;
	assign sts.at_dest  = at_dest;
	assign sts.step_add = step_add;
	assign sts.div_busy = div_busy;

endmodule

`default_nettype wire

### rtl/three_axis_dda_line_stepper.sv
// Three-axis DDA line stepper: command decode, leader pick and result merge.
//
//   port   dir   beat         contents
//   cmd    in    cmd_beat_t   command, target_x, target_y, target_z
//   step   out   step_beat_t  step and dir per axis, moving, done_res, z_disable
//
// Tick, set and unused commands: result registered at the accept edge.
// Start: accept, the leader-pick state, the per-axis serial dividers (one quotient
// bit per cycle), then the rate load, at whose edge the result is registered;
// a zero-length start ends after the leader-pick state.
// cmd.ready is low while a start is in flight or an unread result blocks the slot.
// Reset clears the axis registers (not the divider datapath) and the control; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_dda_line_stepper #(
	parameter int unsigned FRAC_BITS = dda_pkg::FracBitsDef,
	parameter int unsigned POS_BITS  = dda_pkg::PosBitsDef
) (
	input logic clk,
	input logic arst_n,
	dda_if.sink   cmd,
	dda_if.source step
);
	import dda_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic                active_q;
	logic                active_d;
	logic                latch_q;
	logic                latch_d;
	logic [1:0]          leader_q;
	logic [1:0]          leader_d;
	step_beat_t          out_q;
	step_beat_t          out_d;
	logic                out_valid_q;
	logic                out_wr;

	lane_ctl_t           ctl;
	lane_sts_t           sts [NumAxes];
	logic [POS_BITS-1:0] mag [NumAxes];
	logic [POS_BITS-1:0] tgt [NumAxes];
	logic [POS_BITS-1:0] lead_mag;
	logic [1:0]          lead_idx;
	logic                acc_in;
	logic                any_busy;
	logic                at_end;
	logic [NumAxes-1:0]  steps;
	logic                done;

	assign cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || step.ready);
	assign acc_in    = cmd.valid && cmd.ready;
	assign any_busy  = sts[0].div_busy || sts[1].div_busy || sts[2].div_busy;
	assign at_end    = sts[leader_q].at_dest;

	assign tgt[0] = cmd.data.target_x[POS_BITS-1:0];
	assign tgt[1] = cmd.data.target_y[POS_BITS-1:0];
	assign tgt[2] = cmd.data.target_z[POS_BITS-1:0];

	for (genvar a = 0; a < NumAxes; a++) begin : g_lane
		dda_axis #(
			.FRAC_BITS(FRAC_BITS),
			.POS_BITS (POS_BITS)
		) u_axis (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.target(tgt[a]),
			.lead  (lead_mag),
			.mag   (mag[a]),
			.sts   (sts[a])
		);
	end

	// ties keep the earlier axis
	always_comb begin
		lead_mag = mag[0];
		lead_idx = AXIS_X;
		if (mag[1] > lead_mag) begin
			lead_mag = mag[1];
			lead_idx = AXIS_Y;
		end
		if (mag[2] > lead_mag) begin
			lead_mag = mag[2];
			lead_idx = AXIS_Z;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && (cmd_t'(cmd.data.command) == CMD_START)) begin
					state_d = ST_LEAD;
				end
			end
			ST_LEAD: begin
				state_d = (lead_mag == '0) ? ST_IDLE : ST_DIV;
			end
			ST_DIV: begin
				if (!any_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		out_wr   = 1'b0;
		active_d = active_q;
		latch_d  = latch_q;
		leader_d = leader_q;
		steps    = '0;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					case (cmd_t'(cmd.data.command))
						CMD_START: begin
							ctl.start = 1'b1;
							latch_d   = 1'b0;
							active_d  = 1'b0;
						end
						CMD_SET: begin
							ctl.set  = 1'b1;
							active_d = 1'b0;
							out_wr   = 1'b1;
						end
						CMD_TICK: begin
							out_wr = 1'b1;
							if (active_q) begin
								ctl.tick_add = !at_end;
								ctl.tick_end = at_end;
								if (at_end) begin
									// one correction step on each lagging axis
									steps    = {!sts[2].at_dest, !sts[1].at_dest,
										!sts[0].at_dest};
									active_d = 1'b0;
									latch_d  = 1'b1;
									done     = 1'b1;
								end else begin
									steps = {sts[2].step_add, sts[1].step_add,
										sts[0].step_add};
								end
							end
						end
						default: out_wr = 1'b1;
					endcase
				end
			end
			ST_LEAD: begin
				leader_d = lead_idx;
				if (lead_mag == '0) begin
					out_wr   = 1'b1;
					done     = 1'b1;
					latch_d  = 1'b1;
					active_d = 1'b0;
				end else begin
					ctl.div_go = 1'b1;
				end
			end
			ST_DIV: begin
				if (!any_busy) begin
					active_d = 1'b1;
					out_wr   = 1'b1;
				end
			end
			default: ;
		endcase
		out_d.step_x    = steps[0];
		out_d.step_y    = steps[1];
		out_d.step_z    = steps[2];
		out_d.dir_x     = sts[0].dir;
		out_d.dir_y     = sts[1].dir;
		out_d.dir_z     = sts[2].dir;
		out_d.moving    = active_d;
		out_d.done_res  = done;
		out_d.z_disable = latch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			latch_q     <= 1'b0;
			leader_q    <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			latch_q     <= latch_d;
			leader_q    <= leader_d;
			out_valid_q <= out_wr || (out_valid_q && !step.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_q <= out_d;
		end
	end

	assign step.valid = out_valid_q;
	assign step.data  = out_q;

	a_done_latches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.done_res |-> out_q.z_disable && !out_q.moving)
		else $error("done beat without z_disable or still moving");

	a_start_to_lead: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && (cmd_t'(cmd.data.command) == CMD_START) |=> state_q == ST_LEAD)
		else $error("start did not enter leader pick");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd.ready)
		else $error("input taken while a start is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_valid_q || step.ready)
		else $error("result slot overwritten before it was taken");

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sts[0].div_busy) |-> !sts[1].div_busy && !sts[2].div_busy)
		else $error("axis dividers out of step");

endmodule

`default_nettype wire
